// ===== rtl/svpe_pkg.sv =====
// ----------------------------------------------------------------------------
// svpe_pkg
// shared types and constants of the sample voice position engine
// ----------------------------------------------------------------------------
package svpe_pkg;

  localparam int unsigned MAX_FRAMES = 4096;
  localparam int unsigned FRAMES_W   = 13;
  localparam int unsigned EVENT_CAP  = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 88;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_WHOLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_FRAC     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LENGTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LIMIT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VOICE_MODE    = 3'd6;

  localparam logic MODE_ADVANCE = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_MULEND,
    ST_DIV,
    ST_KSET,
    ST_EVENT,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/sample_voice_position_engine.sv =====
// ----------------------------------------------------------------------------
// sample_voice_position_engine
// playback position of one sample voice in 32.32 fixed point with loop,
// ping-pong and loop limit handling
// ----------------------------------------------------------------------------
// channel  direction  fields
// s_axis   in         tuser: mode; tdata: frames, start_position
// m_axis   out        tdata: position, position_frac, playing, backwards,
//                     loops_done
// cfg      in         cfg_index_i, cfg_data_i register write
//
// restart or idle advance: the transfer goes straight to ST_DONE, which loads the output register
// each boundary: 13 step multiply, 13 step divide, 13 step multiply,
// one adder pass each; at most 17 passes per item
// s_axis_tready is high only while the sequencer idles
// a result held in the output register blocks only the next result
// reset clears the position state and loads the register defaults
// ----------------------------------------------------------------------------
module sample_voice_position_engine (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [svpe_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // frames, start_position
  input  logic                               s_axis_tuser,  // mode
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [svpe_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // position, position_frac,
                                                            // playing, backwards, loops_done
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [svpe_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [31:0]                        cfg_data_i
);
  import svpe_pkg::*;

  logic [15:0] step_whole_q;
  logic [31:0] step_frac_q, sample_length_q, loop_start_q, loop_length_q;
  logic [15:0] loop_limit_q;
  logic [2:0]  voice_mode_q;

  state_e state_q, state_d;
  logic signed [63:0] pos_q, pos_d, end_q, end_d, remain_q, remain_d;
  logic [31:0] frac_q, frac_d;
  logic        playing_q, playing_d, back_q, back_d, looping_q, looping_d;
  logic [15:0] pass_q, pass_d;
  logic [FRAMES_W-1:0] left_q, left_d, mq_q, mq_d, quo_q, quo_d;
  logic [4:0]  events_q, events_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        phase_q, phase_d;
  logic [63:0] acc_q, acc_d, rem_q, rem_d;
  logic        ovalid_q, ovalid_d;
  logic [OUT_DATA_W-1:0] odata_q, odata_d;

  logic [47:0] step;
  logic [63:0] step_sh;
  logic signed [63:0] whole, rem_diff;
  logic [FRAMES_W-1:0] in_frames;
  logic [FRAMES_W:0]   kval;

  assign step    = {step_whole_q, step_frac_q};
  assign step_sh = {16'd0, step} << cnt_q;
  assign whole   = $signed({32'd0, acc_q[63:32]});
  assign in_frames = s_axis_tdata[FRAMES_W-1:0];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_whole_q    <= 16'd1;
      step_frac_q     <= '0;
      sample_length_q <= '0;
      loop_start_q    <= '0;
      loop_length_q   <= '0;
      loop_limit_q    <= '0;
      voice_mode_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_STEP_WHOLE:    step_whole_q    <= cfg_data_i[15:0];
        CFG_STEP_FRAC:     step_frac_q     <= cfg_data_i;
        CFG_SAMPLE_LENGTH: sample_length_q <= cfg_data_i;
        CFG_LOOP_START:    loop_start_q    <= cfg_data_i;
        CFG_LOOP_LENGTH:   loop_length_q   <= cfg_data_i;
        CFG_LOOP_LIMIT:    loop_limit_q    <= cfg_data_i[15:0];
        CFG_VOICE_MODE:    voice_mode_q    <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_q     <= '0;
      end_q     <= '0;
      frac_q    <= '0;
      playing_q <= 1'b0;
      back_q    <= 1'b0;
      looping_q <= 1'b0;
      pass_q    <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      end_q     <= end_d;
      frac_q    <= frac_d;
      playing_q <= playing_d;
      back_q    <= back_d;
      looping_q <= looping_d;
      pass_q    <= pass_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    remain_q <= remain_d;
    left_q   <= left_d;
    mq_q     <= mq_d;
    quo_q    <= quo_d;
    events_q <= events_d;
    cnt_q    <= cnt_d;
    phase_q  <= phase_d;
    acc_q    <= acc_d;
    rem_q    <= rem_d;
    odata_q  <= odata_d;
  end

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    end_d     = end_q;
    frac_d    = frac_q;
    playing_d = playing_q;
    back_d    = back_q;
    looping_d = looping_q;
    pass_d    = pass_q;
    remain_d  = remain_q;
    left_d    = left_q;
    mq_d      = mq_q;
    quo_d     = quo_q;
    events_d  = events_q;
    cnt_d     = cnt_q;
    phase_d   = phase_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    ovalid_d  = ovalid_q;
    odata_d   = odata_q;
    rem_diff  = $signed(rem_q - step_sh);
    kval      = {1'b0, quo_q} + 1'b1;

    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_DONE;
          if (s_axis_tuser == MODE_RESTART) begin
            pos_d     = $signed({32'd0, s_axis_tdata[FRAMES_W +: 32]});
            frac_d    = '0;
            playing_d = 1'b1;
            pass_d    = '0;
            back_d    = voice_mode_q[2];
            looping_d = voice_mode_q[0];
            if (voice_mode_q[0]) begin
              end_d = voice_mode_q[2] ? $signed({32'd0, loop_start_q})
                    : $signed({32'd0, loop_start_q} + {32'd0, loop_length_q});
            end else begin
              end_d = voice_mode_q[2] ? -64'sd1 : $signed({32'd0, sample_length_q});
            end
          end else if (playing_q && in_frames != '0) begin
            left_d   = (in_frames > FRAMES_W'(MAX_FRAMES)) ? FRAMES_W'(MAX_FRAMES)
                                                          : in_frames;
            events_d = '0;
            state_d  = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        remain_d = back_q ? pos_q - end_q : end_q - pos_q;
        if (remain_d > 0) begin
          acc_d   = {32'd0, frac_q};
          mq_d    = left_q;
          cnt_d   = '0;
          phase_d = 1'b0;
          state_d = ST_MUL;
        end else begin
          state_d = ST_EVENT;
        end
      end
      ST_MUL: begin
        if (mq_q[cnt_q]) acc_d = acc_q + step_sh;
        if (cnt_q == 4'(FRAMES_W - 1)) state_d = ST_MULEND;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_MULEND: begin
        if (!phase_q && !(whole < remain_q || step == '0)) begin
          rem_d   = {remain_q[31:0], 32'd0} - {32'd0, frac_q} - 64'd1;
          quo_d   = '0;
          cnt_d   = 4'(FRAMES_W - 1);
          state_d = ST_DIV;
        end else begin
          pos_d   = back_q ? pos_q - whole : pos_q + whole;
          frac_d  = acc_q[31:0];
          state_d = phase_q ? ST_EVENT : ST_DONE;
        end
      end
      ST_DIV: begin
        if (rem_q >= step_sh) begin
          rem_d = rem_diff;
          quo_d[cnt_q] = 1'b1;
        end
        if (cnt_q == '0) state_d = ST_KSET;
        else cnt_d = cnt_q - 1'b1;
      end
      ST_KSET: begin
        if (kval > {1'b0, left_q}) kval = {1'b0, left_q};
        left_d  = left_q - kval[FRAMES_W-1:0];
        mq_d    = kval[FRAMES_W-1:0];
        acc_d   = {32'd0, frac_q};
        cnt_d   = '0;
        phase_d = 1'b1;
        state_d = ST_MUL;
      end
      ST_EVENT: begin
        if (!looping_q) begin
          playing_d = 1'b0;
          state_d   = ST_DONE;
        end else if (events_q >= 5'(EVENT_CAP)) begin
          state_d = ST_DONE;
        end else begin
          events_d = events_q + 1'b1;
          if (pass_q != 16'hFFFF) pass_d = pass_q + 1'b1;
          if (loop_limit_q != '0 && loop_limit_q == pass_q) begin
            looping_d = 1'b0;
            end_d = back_q ? -64'sd1 : $signed({32'd0, sample_length_q});
          end else if (voice_mode_q[1]) begin
            pos_d  = (end_q <<< 1) - pos_q;
            back_d = !back_q;
            end_d  = back_q ? end_q + $signed({32'd0, loop_length_q})
                            : end_q - $signed({32'd0, loop_length_q});
          end else begin
            pos_d = back_q ? pos_q + $signed({32'd0, loop_length_q})
                           : pos_q - $signed({32'd0, loop_length_q});
          end
          state_d = (left_q == '0) ? ST_DONE : ST_CHECK;
        end
      end
      ST_DONE: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d  = {6'd0, pass_q, back_q, playing_q, frac_q, pos_q[31:0]};
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/svpe_checker.sv =====
// ----------------------------------------------------------------------------
// svpe_checker
// port level checks of the sample voice position engine
// ----------------------------------------------------------------------------
module svpe_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [svpe_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            cfg_ready_o
);
  import svpe_pkg::*;

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready stayed high after a transfer");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:82] == '0)
    else $error("result padding not zero");

endmodule

bind sample_voice_position_engine svpe_checker u_svpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready_o   (cfg_ready_o)
);
